FILE: rtl/core/bfie_pkg.sv
// bfie_pkg: types and constants for the bit field insert/extract block
// request and response structs, store write bundle, sizing constants
// no dependencies
package bfie_pkg;

  localparam int STORE_BYTES_DEF = 32;
  localparam int BITS_PER_BYTE   = 8;
  localparam int MAX_FIELD_BITS  = 64;
  localparam int VALUE_W         = 64;
  localparam int START_W         = 8;
  localparam int LEN_W           = 7;
  // byte address reach: start byte up to 31 plus up to 8 more bytes
  localparam int ADDR_W          = 6;
  // steps per request: a field spans at most nine bytes
  localparam int STEPS           = 9;
  localparam int STEP_W          = 4;

  typedef enum logic {
    ACT_INSERT  = 1'b0,
    ACT_EXTRACT = 1'b1
  } bfie_act_t;

  typedef struct packed {
    logic                action;
    logic [START_W-1:0]  field_lsb;
    logic [LEN_W-1:0]    bit_length;
    logic [VALUE_W-1:0]  write_value;
  } bfie_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  read_value;
    logic                range_error;
  } bfie_rsp_t;

  // masked byte write into the store
  typedef struct packed {
    logic                     en;
    logic [BITS_PER_BYTE-1:0] mask;
    logic [BITS_PER_BYTE-1:0] data;
  } bfie_wr_t;

endpackage

FILE: rtl/core/bfie_store.sv
// bfie_store: byte store in flip-flops, cleared at reset
// one masked read-modify-write and one read per cycle at a shared address
// depends on bfie_pkg
module bfie_store #(
  parameter int STORE_BYTES = bfie_pkg::STORE_BYTES_DEF,
  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [AW-1:0]                     addr,
  input  bfie_pkg::bfie_wr_t                wr,
  output logic [bfie_pkg::BITS_PER_BYTE-1:0] rd_data
);
  import bfie_pkg::*;

  logic [BITS_PER_BYTE-1:0] mem_r [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_BYTES; i++) begin
        mem_r[i] <= '0;
      end
    end else if (wr.en) begin
      mem_r[addr] <= (mem_r[addr] & ~wr.mask) | (wr.data & wr.mask);
    end
  end

  assign rd_data = mem_r[addr];

endmodule

FILE: rtl/core/bit_field_insert_extract_top.sv
// bit_field_insert_extract_top: bit addressed byte store with lsb-first fields
// byte serial insert and extract engine around bfie_store
// depends on bfie_pkg, bfie_store
//
// A request is taken at a rising edge with start high and busy low. Every
// request then walks nine bytes of the store, one byte per cycle, starting
// at byte field_lsb/8, whatever its length; the single byte port of the
// store is why it goes byte by byte. busy drops during the last step, so
// a new request can be taken at the edge that ends the last step of the
// one before. The response appears in the cycle after the last step with
// out_valid high for exactly one cycle; the receiver cannot stall it, and
// it must take it then. An insert writes only the addressed field bits,
// returns read_value zero, and reports range_error when the field runs
// past the end of the store (those bits are dropped). An extract returns
// the field zero-extended, bits past the end read as zero, range_error as
// for an insert. A length of zero touches nothing and reports no error;
// lengths above 64 act as 64. The store comes out of reset all zero.
module bit_field_insert_extract_top #(
  parameter int STORE_BYTES = bfie_pkg::STORE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bfie_pkg::bfie_req_t in_req,
  output logic                out_valid,
  output bfie_pkg::bfie_rsp_t out_rsp
);
  import bfie_pkg::*;

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int STORE_BITS = STORE_BYTES * BITS_PER_BYTE;
  localparam int SUM_W = START_W + 1;

  // control
  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic              last;
  logic              accept;

  // per request working state
  logic                      act_r;
  logic                      err_r;
  logic [ADDR_W-2:0]         idx0_r;   // first byte touched
  logic [2:0]                sh_r;     // bit offset inside that byte
  logic [LEN_W-1:0]          rem_r;    // field bits not yet masked in
  logic [VALUE_W-1:0]        val_r;    // insert value, shifted out a byte per step
  logic [VALUE_W-1:0]        res_r;    // extract result, shifted in from the top
  logic [BITS_PER_BYTE-1:0]  mu_prev_r;
  logic [BITS_PER_BYTE-1:0]  v_prev_r;
  logic [BITS_PER_BYTE-1:0]  rd_prev_r;

  logic      out_valid_r;
  bfie_rsp_t out_rsp_r;

  // step datapath
  logic [BITS_PER_BYTE-1:0]   mu_cur;
  logic [BITS_PER_BYTE-1:0]   v_cur;
  logic [2*BITS_PER_BYTE-1:0] wide_v;
  logic [2*BITS_PER_BYTE-1:0] wide_m;
  logic [2*BITS_PER_BYTE-1:0] wide_rd;
  logic [ADDR_W-1:0]          addr;
  logic                       in_range;
  logic [BITS_PER_BYTE-1:0]   store_rd;
  logic [BITS_PER_BYTE-1:0]   rd_byte;
  logic [BITS_PER_BYTE-1:0]   out_byte;
  bfie_wr_t                   wr;

  // request decode
  logic [LEN_W-1:0] len_c;
  logic [SUM_W-1:0] end_bit;

  assign last   = busy_r && (step_r == STEP_W'(STEPS - 1));
  assign busy   = busy_r && !last;
  assign accept = start && !busy;

  // lengths above the maximum saturate
  assign len_c   = (in_req.bit_length > LEN_W'(MAX_FIELD_BITS)) ?
                   LEN_W'(MAX_FIELD_BITS) : in_req.bit_length;
  assign end_bit = {1'b0, in_req.field_lsb} + SUM_W'(len_c);

  // unshifted field mask for this byte of the field
  assign mu_cur = (rem_r >= LEN_W'(BITS_PER_BYTE)) ? '1 :
                  BITS_PER_BYTE'((9'd1 << rem_r[2:0]) - 9'd1);
  assign v_cur  = val_r[BITS_PER_BYTE-1:0] & mu_cur;

  // place field bytes at the bit offset, carrying bits from the byte before
  assign wide_v = {v_cur, v_prev_r} << sh_r;
  assign wide_m = {mu_cur, mu_prev_r} << sh_r;

  assign addr     = {1'b0, idx0_r} + ADDR_W'(step_r);
  assign in_range = addr < ADDR_W'(STORE_BYTES);
  assign rd_byte  = in_range ? store_rd : '0;

  // extract lags one step: this byte and the previous one give field byte k-1
  assign wide_rd  = {rd_byte, rd_prev_r} >> sh_r;
  assign out_byte = wide_rd[BITS_PER_BYTE-1:0] & mu_prev_r;

  always_comb begin
    wr.en   = busy_r && (act_r == ACT_INSERT) && in_range;
    wr.mask = wide_m[2*BITS_PER_BYTE-1:BITS_PER_BYTE];
    wr.data = wide_v[2*BITS_PER_BYTE-1:BITS_PER_BYTE];
  end

  bfie_store #(
    .STORE_BYTES(STORE_BYTES)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .addr   (addr[AW-1:0]),
    .wr     (wr),
    .rd_data(store_rd)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last;
      if (accept) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (last) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  // working registers: load on a new request, otherwise advance one byte
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r     <= in_req.action;
      idx0_r    <= in_req.field_lsb[START_W-1:3];
      sh_r      <= in_req.field_lsb[2:0];
      rem_r     <= len_c;
      val_r     <= in_req.write_value;
      err_r     <= (len_c != '0) && (end_bit > SUM_W'(STORE_BITS));
      mu_prev_r <= '0;
      v_prev_r  <= '0;
      rd_prev_r <= '0;
    end else if (busy_r) begin
      val_r     <= val_r >> BITS_PER_BYTE;
      rem_r     <= (rem_r >= LEN_W'(BITS_PER_BYTE)) ?
                   rem_r - LEN_W'(BITS_PER_BYTE) : '0;
      mu_prev_r <= mu_cur;
      v_prev_r  <= v_cur;
      rd_prev_r <= rd_byte;
    end
  end

  // result byte k-1 enters at the top; nothing useful on the first step
  always_ff @(posedge clk) begin
    if (busy_r && (step_r != '0)) begin
      res_r <= {out_byte, res_r[VALUE_W-1:BITS_PER_BYTE]};
    end
  end

  // response register, loaded at the end of the last step
  always_ff @(posedge clk) begin
    if (last) begin
      out_rsp_r.read_value  <= (act_r == ACT_EXTRACT) ?
                               {out_byte, res_r[VALUE_W-1:BITS_PER_BYTE]} : '0;
      out_rsp_r.range_error <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
